@@ rtl/core/cte_pkg.sv @@
// -----------------------------------------------------------------------------
// cte_pkg - shared types and constants for the chunked transfer encoder
// Transaction types for both channels, the internal command format and
// the hex digit helper.
// -----------------------------------------------------------------------------
package cte_pkg;

   // chunk length width kept by the encoder (request length bits above it are dropped)
   localparam int LEN_BITS = 32;
   localparam int NIBBLES  = (LEN_BITS + 3) / 4;
   localparam int HEX_W    = 4 * NIBBLES;
   localparam int DIG_W    = $clog2(NIBBLES + 1);

   // command queue between front and back
   localparam int CQ_DEPTH = 2;
   localparam int CQ_AW    = $clog2(CQ_DEPTH);
   localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

   // result queue at the output of the back end
   localparam int OQ_DEPTH = 2;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   // request actions
   localparam logic ACT_BEGIN = 1'b0;
   localparam logic ACT_DATA  = 1'b1;

   // command kinds
   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_TERM   = 2'd2;
   localparam logic [1:0] CMD_ERROR  = 2'd3;

   // stream characters
   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   typedef struct packed {
      logic        action;
      logic [31:0] chunk_length;
      logic        final_chunk;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       status;
      logic       stream_done;
   } rsp_type;

   // one classified transaction, expanded to bytes by the back end
   typedef struct packed {
      logic [1:0]       kind;
      logic [HEX_W-1:0] hex;        // length, left aligned on its top digit
      logic [DIG_W-1:0] digits;     // number of hex digits to send
      logic [7:0]       data_byte;
      logic             chunk_end;  // data byte closes the chunk
      logic             last_chunk; // closing chunk is followed by terminator
      logic             err_done;   // stream_done shown on an error result
   } cmd_type;

   // lower-case ascii for one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = CHAR_ZERO + {4'h0, nib};
      end else begin
         res = 8'h57 + {4'h0, nib};
      end
      return res;
   endfunction

endpackage

@@ rtl/core/cte_front.sv @@
// -----------------------------------------------------------------------------
// cte_front - request classifier
// Tracks the chunk phase, checks transaction order and turns each accepted
// request into at most one command for the back end.
// -----------------------------------------------------------------------------
module cte_front
   import cte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    cmd_push,
   output cmd_type cmd
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   logic [1:0]          phase_ff, phase_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic                final_ff, final_in;

   logic [LEN_BITS-1:0] len;
   logic [HEX_W-1:0]    len_ext;
   logic [DIG_W-1:0]    digits;
   logic [DIG_W-1:0]    pad;
   logic                phase_bad;

   // hex digit count and left-aligned length
   always_comb begin
      len     = req.chunk_length[LEN_BITS-1:0];
      len_ext = HEX_W'(len);
      digits  = '0;
      for (int i = 0; i < NIBBLES; i++) begin
         if (len_ext[4*i +: 4] != 4'h0) begin
            digits = DIG_W'(i + 1);
         end
      end
      pad = DIG_W'(NIBBLES) - digits;
   end

   // classification and next state
   always_comb begin
      phase_in      = phase_ff;
      left_in       = left_ff;
      final_in      = final_ff;
      cmd_push      = 1'b0;
      cmd           = '0;
      cmd.data_byte = req.data_byte;
      cmd.err_done  = (phase_ff != PH_IDLE) && (phase_ff != PH_DATA);
      phase_bad     = (req.action == ACT_BEGIN) ? (phase_ff != PH_IDLE)
                                                : (phase_ff != PH_DATA);
      if (accept) begin
         priority if (phase_bad) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_ERROR;
         end else if (req.action == ACT_BEGIN) begin
            if (len == '0) begin
               // empty chunk: terminator if closing, otherwise nothing
               if (req.final_chunk) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_TERM;
                  phase_in = PH_DONE;
                  left_in  = '0;
                  final_in = 1'b0;
               end
            end else begin
               cmd_push   = 1'b1;
               cmd.kind   = CMD_HEADER;
               cmd.hex    = len_ext << {pad, 2'b00};
               cmd.digits = digits;
               phase_in   = PH_DATA;
               left_in    = len;
               final_in   = req.final_chunk;
            end
         end else begin
            cmd_push       = 1'b1;
            cmd.kind       = CMD_DATA;
            cmd.chunk_end  = (left_ff == LEN_BITS'(1));
            cmd.last_chunk = final_ff;
            left_in        = left_ff - LEN_BITS'(1);
            if (left_ff == LEN_BITS'(1)) begin
               phase_in = final_ff ? PH_DONE : PH_IDLE;
               final_in = 1'b0;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= '0;
         final_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         final_ff <= final_in;
      end
   end

endmodule

@@ rtl/core/cte_cmd_queue.sv @@
// -----------------------------------------------------------------------------
// cte_cmd_queue - command queue between front and back end
// Small first-in first-out store that lets either side stall on its own.
// -----------------------------------------------------------------------------
module cte_cmd_queue
   import cte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type data_in,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type data_out
);

   cmd_type          slot_ff [CQ_DEPTH];
   logic [CQ_AW-1:0] wr_ff, wr_in;
   logic [CQ_AW-1:0] rd_ff, rd_in;
   logic [CQ_CW-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CQ_CW'(CQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign data_out = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ff + CQ_AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ff + CQ_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CQ_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= data_in;
      end
   end

endmodule

@@ rtl/core/cte_back.sv @@
// -----------------------------------------------------------------------------
// cte_back - byte sequencer
// Expands each command into encoded stream bytes, one per cycle while not
// stalled, and holds them in a short result queue toward the output port.
// -----------------------------------------------------------------------------
module cte_back
   import cte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam logic [3:0] SEQ_DIGIT = 4'd0;
   localparam logic [3:0] SEQ_BYTE  = 4'd1;
   localparam logic [3:0] SEQ_CR1   = 4'd2;
   localparam logic [3:0] SEQ_LF1   = 4'd3;
   localparam logic [3:0] SEQ_T0    = 4'd4;
   localparam logic [3:0] SEQ_TCR1  = 4'd5;
   localparam logic [3:0] SEQ_TLF1  = 4'd6;
   localparam logic [3:0] SEQ_TCR2  = 4'd7;
   localparam logic [3:0] SEQ_TLF2  = 4'd8;
   localparam logic [3:0] SEQ_ERR   = 4'd9;

   // current command
   logic             busy_ff, busy_in;
   logic [3:0]       seq_ff, seq_in;
   logic [HEX_W-1:0] hex_ff, hex_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic [7:0]       byte_ff, byte_in;
   logic             end_ff, end_in;
   logic             last_ff, last_in;
   logic             done_ff, done_in;

   // result queue
   rsp_type          oq_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] oq_wr_ff, oq_wr_in;
   logic [OQ_AW-1:0] oq_rd_ff, oq_rd_in;
   logic [OQ_CW-1:0] oq_cnt_ff, oq_cnt_in;
   logic             oq_full, oq_pop;

   logic             emit, last_step;
   rsp_type          res;
   logic [3:0]       load_seq;

   assign oq_full   = (oq_cnt_ff == OQ_CW'(OQ_DEPTH));
   assign rsp_empty = (oq_cnt_ff == '0);
   assign rsp_data  = oq_ff[oq_rd_ff];
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign emit      = busy_ff && !oq_full;

   // byte for the current step
   always_comb begin
      res       = '0;
      last_step = 1'b0;
      unique case (seq_ff)
         SEQ_DIGIT: res.out_byte = hex_char(hex_ff[HEX_W-1 -: 4]);
         SEQ_BYTE: begin
            res.out_byte = byte_ff;
            last_step    = !end_ff;
         end
         SEQ_CR1: res.out_byte = CHAR_CR;
         SEQ_LF1: begin
            res.out_byte = CHAR_LF;
            last_step    = !last_ff;
         end
         SEQ_T0:   res.out_byte = CHAR_ZERO;
         SEQ_TCR1: res.out_byte = CHAR_CR;
         SEQ_TLF1: res.out_byte = CHAR_LF;
         SEQ_TCR2: res.out_byte = CHAR_CR;
         SEQ_TLF2: begin
            res.out_byte    = CHAR_LF;
            res.stream_done = 1'b1;
            last_step       = 1'b1;
         end
         SEQ_ERR: begin
            res.status      = 1'b1;
            res.stream_done = done_ff;
            last_step       = 1'b1;
         end
         default: last_step = 1'b1;
      endcase
      res.run_end = last_step;
   end

   // first step of the queued command
   always_comb begin
      unique case (cmd_head.kind)
         CMD_HEADER: load_seq = SEQ_DIGIT;
         CMD_DATA:   load_seq = SEQ_BYTE;
         CMD_TERM:   load_seq = SEQ_T0;
         CMD_ERROR:  load_seq = SEQ_ERR;
         default:    load_seq = SEQ_ERR;
      endcase
   end

   assign cmd_pop = !cmd_empty && (!busy_ff || (emit && last_step));

   // sequencer next state
   always_comb begin
      busy_in = busy_ff;
      seq_in  = seq_ff;
      hex_in  = hex_ff;
      dig_in  = dig_ff;
      byte_in = byte_ff;
      end_in  = end_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (cmd_pop) begin
         busy_in = 1'b1;
         seq_in  = load_seq;
         hex_in  = cmd_head.hex;
         dig_in  = cmd_head.digits;
         byte_in = cmd_head.data_byte;
         end_in  = cmd_head.chunk_end;
         last_in = cmd_head.last_chunk;
         done_in = cmd_head.err_done;
      end else if (emit && last_step) begin
         busy_in = 1'b0;
      end else if (emit) begin
         unique case (seq_ff)
            SEQ_DIGIT: begin
               hex_in = hex_ff << 4;
               dig_in = dig_ff - DIG_W'(1);
               seq_in = (dig_ff == DIG_W'(1)) ? SEQ_CR1 : SEQ_DIGIT;
            end
            SEQ_BYTE: seq_in = SEQ_CR1;
            SEQ_CR1:  seq_in = SEQ_LF1;
            SEQ_LF1:  seq_in = SEQ_T0;
            SEQ_T0:   seq_in = SEQ_TCR1;
            SEQ_TCR1: seq_in = SEQ_TLF1;
            SEQ_TLF1: seq_in = SEQ_TCR2;
            SEQ_TCR2: seq_in = SEQ_TLF2;
            default:  seq_in = SEQ_ERR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seq_ff  <= SEQ_ERR;
      end else begin
         busy_ff <= busy_in;
         seq_ff  <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      hex_ff  <= hex_in;
      dig_ff  <= dig_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   // result queue pointers and count
   always_comb begin
      oq_wr_in  = oq_wr_ff;
      oq_rd_in  = oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (emit) begin
         oq_wr_in = (oq_wr_ff == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_ff + OQ_AW'(1);
      end
      if (oq_pop) begin
         oq_rd_in = (oq_rd_ff == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_ff + OQ_AW'(1);
      end
      if (emit && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + OQ_CW'(1);
      end else if (oq_pop && !emit) begin
         oq_cnt_in = oq_cnt_ff - OQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

endmodule

@@ rtl/core/chunked_transfer_encoder_unit.sv @@
// -----------------------------------------------------------------------------
// chunked_transfer_encoder_unit - chunked transfer coding framer
// Frames a body stream as chunks: hex length line, body bytes, chunk
// trailer and the closing terminator, with an error result on bad order.
// -----------------------------------------------------------------------------
//   channel   handshake          payload
//   request   push / full        req_data  (action, length, final, byte)
//   result    empty / pop        rsp_data  (byte, run_end, status, done)
//
// - a request transaction is taken every cycle while the command queue has room
// - the back end sends one byte per cycle unless stalled: a begin gives digits
//   + 2 bytes (3 to 10), an empty last begin 5, an empty non-last begin none,
//   a body byte 1, a chunk-closing byte 3, a final one 8, an out-of-order one 1
// - the first byte passes command queue, sequencer and result queue to the ports
// - reset is synchronous; it clears phase, queues and sequencer
// - a stalled result side fills the two-entry result queue, the sequencer and
//   the two-entry command queue, then raises full
// -----------------------------------------------------------------------------
module chunked_transfer_encoder_unit
   import cte_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_new, cmd_head;

   assign accept = push && !full;
   assign full   = cmd_full;

   // order check and classification
   cte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd_new)
   );

   // decoupling queue
   cte_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  (cmd_new),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .data_out (cmd_head)
   );

   // byte generation
   cte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/cte_checker.sv @@
// -----------------------------------------------------------------------------
// cte_checker - port-level checks for the chunked transfer encoder
// Watches the top-level ports and flags inconsistent result transactions.
// -----------------------------------------------------------------------------
module cte_checker
   import cte_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // an error result is always the only result of its transaction
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status) |-> (rsp_data.run_end && rsp_data.out_byte == 8'h00))
      else $error("error result malformed");

   // an ok done result is the closing line feed of the terminator
   a_done_close: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.status && rsp_data.stream_done)
         |-> (rsp_data.run_end && rsp_data.out_byte == CHAR_LF))
      else $error("stream_done on wrong byte");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

bind chunked_transfer_encoder_unit cte_checker u_cte_checker (.*);
